// ===== hdl/md5_pkg.sv =====
// ============================================================================
// MD5 package
// Shared types, round constants and helper functions of the MD5 digest block.
// ============================================================================
`default_nettype none

package md5_pkg;

   localparam logic [31:0] INIT_A = 32'h6745_2301;
   localparam logic [31:0] INIT_B = 32'hefcd_ab89;
   localparam logic [31:0] INIT_C = 32'h98ba_dcfe;
   localparam logic [31:0] INIT_D = 32'h1032_5476;

   localparam logic [7:0] PAD_MARK  = 8'h80;
   localparam logic [7:0] PAD_ZERO  = 8'h00;
   localparam logic [5:0] LAST_POS  = 6'd63;
   localparam logic [5:0] LEN_POS   = 6'd56;
   localparam logic [3:0] LEN_WORD0 = 4'd14;
   localparam logic [3:0] LEN_WORD1 = 4'd15;

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_S [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef struct packed {
      logic       wr_byte;
      logic       wr_mark;
      logic       wr_zero;
      logic       wr_len;
      logic       load;
      logic       round;
      logic       fold;
      logic       emit;
      logic [5:0] round_idx;
   } cmd_type;

   typedef struct packed {
      logic [5:0] pos;
      logic [5:0] ptr;
   } sts_type;

   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] q;
      logic [3:0] g;
      q = r[3:0];
      case (r[5:4])
         2'd0:    g = q;
         2'd1:    g = {q[1:0], 2'b00} + q + 4'd1;
         2'd2:    g = {q[2:0], 1'b0} + q + 4'd5;
         default: g = {q[0], 3'b000} - q;
      endcase
      return g;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] r);
      return ROT_S[{r[5:4], r[1:0]}];
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] t;
      t = {v, v} << s;
      return t[63:32];
   endfunction

   function automatic logic [31:0] bswap(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/md5_dp.sv =====
// ============================================================================
// MD5 datapath
// Message block, byte counter, padding pointer, round unit, chaining words
// and digest output register.
// ============================================================================
`default_nettype none

module md5_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       req_data_byte,
   input  wire md5_pkg::cmd_type cmd,
   output md5_pkg::sts_type      sts,
   output logic [63:0]           rsp_digest_high,
   output logic [63:0]           rsp_digest_low
);

   logic [31:0] block_ff [16];
   logic [31:0] chain_ff [4];
   logic [31:0] work_ff  [4];
   logic [31:0] pre_ff;
   logic [31:0] pre_in;
   logic [60:0] count_ff;
   logic [5:0]  ptr_ff;
   logic [63:0] high_ff;
   logic [63:0] low_ff;

   logic [5:0]  pos;
   logic [5:0]  wpos;
   logic [7:0]  wdata;
   logic [63:0] bit_len;
   logic [31:0] fval;
   logic [31:0] rot_val;
   logic [31:0] new_b;
   logic [5:0]  nxt_idx;
   logic [31:0] pre_base;

   assign pos     = count_ff[5:0];
   assign bit_len = {count_ff, 3'b000};
   assign sts.pos = pos;
   assign sts.ptr = ptr_ff;

   always_comb begin
      wpos  = pos;
      wdata = req_data_byte;
      if (cmd.wr_mark) begin
         wdata = md5_pkg::PAD_MARK;
      end else if (cmd.wr_zero) begin
         wpos  = ptr_ff;
         wdata = md5_pkg::PAD_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_byte || cmd.wr_mark || cmd.wr_zero) begin
         block_ff[wpos[5:2]][{wpos[1:0], 3'b000} +: 8] <= wdata;
      end
      if (cmd.wr_len) begin
         block_ff[md5_pkg::LEN_WORD0] <= bit_len[31:0];
         block_ff[md5_pkg::LEN_WORD1] <= bit_len[63:32];
      end
   end

   always_comb begin
      case (cmd.round_idx[5:4])
         2'd0:    fval = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         2'd1:    fval = (work_ff[1] & work_ff[3]) | (work_ff[2] & ~work_ff[3]);
         2'd2:    fval = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         default: fval = work_ff[2] ^ (work_ff[1] | ~work_ff[3]);
      endcase
      rot_val  = md5_pkg::rotl(fval + pre_ff, md5_pkg::rot_amount(cmd.round_idx));
      new_b    = work_ff[1] + rot_val;
      nxt_idx  = cmd.load ? 6'd0 : cmd.round_idx + 6'd1;
      pre_base = cmd.load ? chain_ff[0] : work_ff[3];
      pre_in   = pre_base + md5_pkg::ROUND_K[nxt_idx]
               + block_ff[md5_pkg::msg_index(nxt_idx)];
   end

   always_ff @(posedge clock) begin
      if (cmd.load || cmd.round) begin
         pre_ff <= pre_in;
      end
      if (cmd.load) begin
         work_ff <= chain_ff;
      end else if (cmd.round) begin
         work_ff[0] <= work_ff[3];
         work_ff[1] <= new_b;
         work_ff[2] <= work_ff[1];
         work_ff[3] <= work_ff[2];
      end
      if (cmd.wr_mark) begin
         ptr_ff <= pos + 6'd1;
      end else if (cmd.wr_zero) begin
         ptr_ff <= ptr_ff + 6'd1;
      end
      if (cmd.emit) begin
         high_ff <= {md5_pkg::bswap(chain_ff[0]), md5_pkg::bswap(chain_ff[1])};
         low_ff  <= {md5_pkg::bswap(chain_ff[2]), md5_pkg::bswap(chain_ff[3])};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         chain_ff[0] <= md5_pkg::INIT_A;
         chain_ff[1] <= md5_pkg::INIT_B;
         chain_ff[2] <= md5_pkg::INIT_C;
         chain_ff[3] <= md5_pkg::INIT_D;
         count_ff    <= '0;
      end else begin
         if (cmd.fold) begin
            for (int i = 0; i < 4; i++) begin
               chain_ff[i] <= chain_ff[i] + work_ff[i];
            end
         end
         if (cmd.wr_byte) begin
            count_ff <= count_ff + 61'd1;
         end
      end
   end

   assign rsp_digest_high = high_ff;
   assign rsp_digest_low  = low_ff;

endmodule

`default_nettype wire

// ===== hdl/md5_ctrl.sv =====
// ============================================================================
// MD5 controller
// Sequences byte intake, padding, length insertion, the 64 compression
// rounds and delivery of the digest item.
// ============================================================================
`default_nettype none

module md5_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_has_byte,
   input  wire logic             req_last,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output md5_pkg::cmd_type      cmd,
   input  wire md5_pkg::sts_type sts
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MARK  = 8'b0000_0010,
      ST_ZERO  = 8'b0000_0100,
      ST_LEN   = 8'b0000_1000,
      ST_LOAD  = 8'b0001_0000,
      ST_ROUND = 8'b0010_0000,
      ST_FOLD  = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      RET_BYTE = 2'd0,
      RET_ZERO = 2'd1,
      RET_LEN  = 2'd2
   } ret_type;

   state_type  state_ff, state_in;
   ret_type    ret_ff, ret_in;
   logic [5:0] round_ff, round_in;
   logic       last_ff, last_in;
   logic       wrap_ff, wrap_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      round_in     = round_ff;
      last_in      = last_ff;
      wrap_in      = wrap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.round_idx = round_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_has_byte) begin
                  cmd.wr_byte = 1'b1;
                  last_in     = req_last;
                  if (sts.pos == md5_pkg::LAST_POS) begin
                     ret_in   = RET_BYTE;
                     state_in = ST_LOAD;
                  end else if (req_last) begin
                     state_in = ST_MARK;
                  end
               end else if (req_last) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            cmd.wr_mark = 1'b1;
            wrap_in     = sts.pos >= md5_pkg::LEN_POS;
            state_in    = ST_ZERO;
            if (sts.pos == md5_pkg::LAST_POS) begin
               wrap_in  = 1'b0;
               ret_in   = RET_ZERO;
               state_in = ST_LOAD;
            end
         end
         ST_ZERO: begin
            if (!wrap_ff && sts.ptr == md5_pkg::LEN_POS) begin
               state_in = ST_LEN;
            end else begin
               cmd.wr_zero = 1'b1;
               if (sts.ptr == md5_pkg::LAST_POS) begin
                  wrap_in  = 1'b0;
                  ret_in   = RET_ZERO;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LEN: begin
            cmd.wr_len = 1'b1;
            ret_in     = RET_LEN;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            round_in = 6'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == md5_pkg::LAST_POS) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            case (ret_ff)
               RET_BYTE: state_in = last_ff ? ST_MARK : ST_IDLE;
               RET_ZERO: state_in = ST_ZERO;
               RET_LEN:  state_in = ST_OUT;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               last_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= RET_BYTE;
         round_ff     <= '0;
         last_ff      <= 1'b0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         round_ff     <= round_in;
         last_ff      <= last_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("digest item raised outside delivery");
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == md5_pkg::LAST_POS) |=> state_ff == ST_FOLD)
      else $error("compression did not end after the last round");
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_has_byte && sts.pos == md5_pkg::LAST_POS)
      |=> state_ff == ST_LOAD)
      else $error("full block not compressed");
   a_len_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LEN |=> (state_ff == ST_LOAD && ret_ff == RET_LEN))
      else $error("length word not followed by final compression");
`endif

endmodule

`default_nettype wire

// ===== hdl/md5_message_digest.sv =====
// ============================================================================
// MD5 message digest
// Takes a message one byte per item and returns the 128-bit digest at the end.
//
//   channel  direction  fields
//   req_     in         data_byte[7:0], has_byte, last
//   rsp_     out        digest_high[63:0], digest_low[63:0]
//
// A byte item is taken while the controller is idle; the byte that fills a
// 64-byte block runs the shared round unit (load, 64 rounds, fold) first.
// An end item is taken in, then the 0x80 mark and each zero byte are written,
// a step closes the padding, the length is written, one or two compressions
// run, and the digest is delivered.
// Reset is synchronous; no clearing pass is needed.
// A stalled digest item holds in the output register while the next message
// is taken in; delivery of the following digest waits for it.
// ============================================================================
`default_nettype none

module md5_message_digest (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_digest_high,
   output logic [63:0]      rsp_digest_low
);

   md5_pkg::cmd_type cmd;
   md5_pkg::sts_type sts;

   md5_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_has_byte (req_has_byte),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .sts          (sts)
   );

   md5_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_digest_high (rsp_digest_high),
      .rsp_digest_low  (rsp_digest_low)
   );

endmodule

`default_nettype wire
